// ----- rtl/tpeq_pkg.sv -----
// tpeq_pkg: shared types and constants for the timed priority event queue
// entry layout, cell operation codes and result status codes
// no dependencies
package tpeq_pkg;

    localparam int TIME_W = 18;
    localparam logic [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

    // result status codes
    localparam logic [2:0] STAT_ACCEPTED   = 3'd0;
    localparam logic [2:0] STAT_FULL       = 3'd1;
    localparam logic [2:0] STAT_EMPTY      = 3'd2;
    localparam logic [2:0] STAT_WAITING    = 3'd3;
    localparam logic [2:0] STAT_DISPATCHED = 3'd4;

    // register indexes on the configuration port
    localparam logic CFG_NODE_MASK  = 1'b0;
    localparam logic CFG_STEP_TICKS = 1'b1;

    // one queue entry: signed remaining delay and the message
    typedef struct packed {
        logic [TIME_W-1:0] ticks;
        logic [10:0]       command;
        logic [5:0]        source;
        logic [5:0]        target;
        logic [31:0]       payload;
    } entry_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CMP,
        OP_INSERT,
        OP_SHIFT,
        OP_SUB
    } cell_op_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t    op;
        logic [15:0] amount;
        entry_t      fresh;
    } cell_ctrl_t;

endpackage

// ----- rtl/timed_priority_event_queue.sv -----
// timed_priority_event_queue: top level, sequencer and output register
// instantiates a chain of tpeq_cell slots
// depends on tpeq_pkg and tpeq_cell
//
// Delay-ordered queue of bus messages held in a chain of QUEUE_DEPTH cells, the
// head in cell 0. Each request arrives on the s_ side; func in s_tuser selects
// enqueue (0) or service (1), and exactly one result leaves on the m_ side with
// its status in m_tuser. An enqueue passes from acceptance through a compare step
// in which every cell compares its entry with the new one, the insertion shift,
// a step that hands the result to the output register and the idle state in
// which the next request is taken. An enqueue refused because the queue is full
// skips the compare and the shift. A service costs one shift of the chain for
// every popped head, and a dispatch costs one more for the final subtraction
// over all cells. A finished result waits in the output register while the
// next request is accepted; a result that finds the output register still
// occupied holds the sequencer until the result side takes the earlier one.
// Configuration writes are taken at any time but belong to idle periods.
module timed_priority_event_queue
    import tpeq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int NODE_SLOTS  = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // delay[15:0], command[26:16], source_node[32:27], target_node[38:33],
    // payload[70:39], zero fill [71]
    input  logic [71:0] s_tdata,
    // func
    input  logic        s_tuser,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // sleep_ticks[15:0], out_command[26:16], out_source[32:27],
    // out_target[38:33], out_payload[70:39], dropped_count[75:71], zero fill
    output logic [79:0] m_tdata,
    // status
    output logic [2:0]  m_tuser,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_INS,
        S_SRV,
        S_SUB,
        S_DONE
    } state_t;

    state_t        state_reg;
    logic [CNT_W-1:0] count_reg;
    logic          func_reg;
    entry_t        req_reg;
    logic [63:0]   mask_reg;
    logic [7:0]    step_reg;
    logic [4:0]    dropped_reg;
    // pending result
    logic [2:0]    res_status_reg;
    logic [15:0]   res_sleep_reg;
    entry_t        res_msg_reg;
    // output register
    logic          m_tvalid_reg;
    logic [79:0]   m_tdata_reg;
    logic [2:0]    m_tuser_reg;

    cell_ctrl_t    ctrl;
    entry_t        cells [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0] ins_chain;

    entry_t        head;
    logic          head_pending;   // head delay still positive
    logic          queue_full;
    logic          queue_empty;
    logic          tgt_in_range;
    logic          tgt_present;

    // ---------------------------------------------------------------
    // head of queue and node lookup
    // ---------------------------------------------------------------
    assign head         = cells[0];
    assign head_pending = !head.ticks[TIME_W-1] && (head.ticks != '0);
    assign queue_full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign queue_empty  = (count_reg == '0);
    assign tgt_in_range = ({1'b0, head.target} < 7'(NODE_SLOTS));
    assign tgt_present  = tgt_in_range && mask_reg[head.target];

    // ---------------------------------------------------------------
    // command broadcast to the chain
    // ---------------------------------------------------------------
    always_comb
    begin
        ctrl.op     = OP_HOLD;
        ctrl.amount = '0;
        ctrl.fresh  = req_reg;
        case (state_reg)
            S_CMP: ctrl.op = OP_CMP;
            S_INS: ctrl.op = OP_INSERT;
            S_SRV:
            begin
                if (!queue_empty)
                begin
                    if (head_pending)
                    begin
                        // head delay fits 16 bits while positive
                        ctrl.op     = OP_SUB;
                        ctrl.amount = head.ticks[15:0];
                    end
                    else
                        ctrl.op = OP_SHIFT;
                end
            end
            S_SUB:
            begin
                ctrl.op     = OP_SUB;
                ctrl.amount = {8'd0, step_reg};
            end
            default: ctrl.op = OP_HOLD;
        endcase
    end

    // ---------------------------------------------------------------
    // chain of cells: insertion flag ripples from the head downwards
    // ---------------------------------------------------------------
    assign ins_chain[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;

        if (i == 0)
        begin : g_first
            assign left_e = req_reg;
        end
        else
        begin : g_mid
            assign left_e = cells[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_e = cells[i];
        end
        else
        begin : g_inner
            assign right_e = cells[i+1];
        end

        tpeq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .occupied (CNT_W'(i) < count_reg),
            .left     (left_e),
            .right    (right_e),
            .ins_in   (ins_chain[i]),
            .ins_out  (ins_chain[i+1]),
            .entry    (cells[i])
        );
    end

    // ---------------------------------------------------------------
    // sequencer, configuration and output register
    // ---------------------------------------------------------------
    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            func_reg       <= 1'b0;
            req_reg        <= '0;
            mask_reg       <= '0;
            step_reg       <= 8'd1;
            dropped_reg    <= '0;
            res_status_reg <= STAT_ACCEPTED;
            res_sleep_reg  <= '0;
            res_msg_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= STAT_ACCEPTED;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NODE_MASK:  mask_reg <= cfg_data;
                    CFG_STEP_TICKS: step_reg <= cfg_data[7:0];
                    default:        mask_reg <= mask_reg;
                endcase
            end

            // result taken; in the final step a waiting result reloads it instead
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE))
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        func_reg          <= s_tuser;
                        req_reg.ticks     <= {2'b00, s_tdata[15:0]};
                        req_reg.command   <= s_tdata[26:16];
                        req_reg.source    <= s_tdata[32:27];
                        req_reg.target    <= s_tdata[38:33];
                        req_reg.payload   <= s_tdata[70:39];
                        dropped_reg       <= '0;
                        res_sleep_reg     <= '0;
                        res_msg_reg       <= '0;
                        res_status_reg    <= STAT_ACCEPTED;
                        if (s_tuser)
                            state_reg <= S_SRV;
                        else if (queue_full)
                        begin
                            res_status_reg <= STAT_FULL;
                            state_reg      <= S_DONE;
                        end
                        else
                            state_reg <= S_CMP;
                    end
                end
                S_CMP: state_reg <= S_INS;
                S_INS:
                begin
                    count_reg      <= count_reg + 1'b1;
                    res_status_reg <= STAT_ACCEPTED;
                    state_reg      <= S_DONE;
                end
                S_SRV:
                begin
                    if (queue_empty)
                    begin
                        res_status_reg <= STAT_EMPTY;
                        res_sleep_reg  <= 16'd1;
                        state_reg      <= S_DONE;
                    end
                    else if (head_pending)
                    begin
                        res_status_reg <= STAT_WAITING;
                        res_sleep_reg  <= head.ticks[15:0];
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        // head is due: pop it, dispatch or drop
                        count_reg <= count_reg - 1'b1;
                        if (tgt_present)
                        begin
                            res_status_reg <= STAT_DISPATCHED;
                            res_sleep_reg  <= {8'd0, step_reg};
                            res_msg_reg    <= head;
                            state_reg      <= S_SUB;
                        end
                        else
                            dropped_reg <= dropped_reg + 1'b1;
                    end
                end
                S_SUB: state_reg <= S_DONE;
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_status_reg;
                        if (func_reg)
                            m_tdata_reg <= {4'd0, dropped_reg, res_msg_reg.payload,
                                            res_msg_reg.target, res_msg_reg.source,
                                            res_msg_reg.command, res_sleep_reg};
                        else
                            m_tdata_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insertion did not add one entry");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRV && !queue_empty && !head_pending)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop of a due head did not remove one entry");

    a_full_no_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser && queue_full) |=> (state_reg == S_DONE))
        else $error("enqueue into a full queue went on to insert");
`endif

endmodule

// ----- rtl/tpeq_cell.sv -----
// tpeq_cell: one slot of the sorted entry chain
// compares against a new request, shifts to either neighbour, subtracts a delay
// depends on tpeq_pkg
module tpeq_cell
    import tpeq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  entry_t     left,
    input  entry_t     right,
    input  logic       ins_in,
    output logic       ins_out,
    output entry_t     entry
);

    entry_t            entry_reg;
    entry_t            entry_next;
    logic              pred_reg;
    logic              pred_next;
    logic [TIME_W-1:0] clamped;
    logic [TIME_W:0]   diff;
    logic [TIME_W-1:0] sub_val;

    // negative delays compare as zero
    always_comb
    begin
        clamped   = entry_reg.ticks[TIME_W-1] ? '0 : entry_reg.ticks;
        pred_next = !occupied
                    || (ctrl.fresh.ticks < clamped)
                    || ((ctrl.fresh.ticks == clamped)
                        && (ctrl.fresh.command < entry_reg.command));
    end

    // saturating subtract at the negative bound
    always_comb
    begin
        diff    = {entry_reg.ticks[TIME_W-1], entry_reg.ticks}
                  - {{(TIME_W+1-16){1'b0}}, ctrl.amount};
        sub_val = (diff[TIME_W] != diff[TIME_W-1]) ? TIME_MIN : diff[TIME_W-1:0];
    end

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (ins_in)
                    entry_next = left;
                else if (pred_reg)
                    entry_next = ctrl.fresh;
            end
            OP_SHIFT: entry_next = right;
            OP_SUB:   entry_next.ticks = sub_val;
            default:  entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pred_reg <= 1'b0;
        else if (ctrl.op == OP_CMP)
            pred_reg <= pred_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign ins_out = ins_in | pred_reg;
    assign entry   = entry_reg;

endmodule
